// File: hdl/rational_arith_reduce_defines.svh
// Assertion macros used by the verification file rar_checker.sv of the rational reducer.
// Each macro expands to one labeled concurrent assertion on clock and reset.
// Needs signals named clock and reset in the scope that uses it.
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH

// Same-cycle implication.
`define RAR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RAR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/rar_pkg.sv
// Shared types and constants of the rational add/sub/mul/div reducer.
// No dependencies; used by every module of the block.
package rar_pkg;

   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int ACTION_WIDTH      = 2;
   localparam int RES_WIDTH         = 33;
   localparam int RSP_DATA_WIDTH    = ((2 * RES_WIDTH + 7) / 8) * 8;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef enum logic {
      ALU_ADD     = 1'b0,
      ALU_ABSDIFF = 1'b1
   } alu_op_type;

   // Result flags handed from the sequencer to the output stage.
   typedef struct packed {
      logic num_neg;
      logic den_neg;
      logic status;
   } rar_flags_type;

endpackage

// File: hdl/rar_mult.sv
// Registered unsigned multiplier shared by the three cross products.
// Depends on nothing; the product is registered and appears in the cycle after the operands.
module rar_mult #(
   parameter int W = rar_pkg::OPERAND_WIDTH_DEF
) (
   input  logic           clock,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic [2*W-1:0] p
);

   logic [2*W-1:0] p_ff;
   logic [2*W-1:0] p_in;

   assign p_in = a * b;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

// File: hdl/rar_alu.sv
// Shared add / absolute-difference unit with magnitude compare.
// Depends on rar_pkg for the operation code.
module rar_alu #(
   parameter int MW = 2 * rar_pkg::OPERAND_WIDTH_DEF
) (
   input  logic [MW-1:0]       a,
   input  logic [MW-1:0]       b,
   input  rar_pkg::alu_op_type op,
   output logic [MW-1:0]       y,
   output logic                lt
);

   logic          is_sub;
   logic [MW-1:0] big;
   logic [MW-1:0] small_op;
   logic [MW-1:0] addend;

   always_comb begin
      lt       = (a < b);
      is_sub   = (op == rar_pkg::ALU_ABSDIFF);
      big      = (is_sub && lt) ? b : a;
      small_op = (is_sub && lt) ? a : b;
      addend   = is_sub ? ~small_op : small_op;
      y        = big + addend + MW'(is_sub);
   end

endmodule

// File: hdl/rar_core.sv
// Sequencer and datapath: cross products, binary GCD, exact divisions.
// Depends on rar_pkg, rar_mult and rar_alu.
module rar_core #(
   parameter int W = rar_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  rar_pkg::action_type    action,
   input  logic [W-1:0]           a_num,
   input  logic [W-1:0]           a_den,
   input  logic [W-1:0]           b_num,
   input  logic [W-1:0]           b_den,
   output logic                   idle,
   output logic                   done,
   input  logic                   take,
   output logic [2*W-1:0]         num_mag,
   output logic [2*W-1:0]         den_mag,
   output rar_pkg::rar_flags_type flags
);

   localparam int MW = 2 * W;
   localparam int CW = $clog2(MW);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_COMB, ST_GCD, ST_DIVN, ST_DIVD, ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   rar_pkg::action_type    act_ff, act_in;
   logic [W-1:0]           an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic                   an_neg_ff, an_neg_in, ad_neg_ff, ad_neg_in;
   logic                   bn_neg_ff, bn_neg_in, bd_neg_ff, bd_neg_in;
   logic [MW-1:0]          p1_ff, p1_in, p2_ff, p2_in;
   logic [MW-1:0]          u_ff, u_in, v_ff, v_in, nq_ff, nq_in, dq_ff, dq_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   rar_pkg::rar_flags_type flags_ff, flags_in;

   logic [W-1:0]        mul_a, mul_b;
   logic [MW-1:0]       prod;
   logic [MW-1:0]       alu_a, alu_b, alu_y;
   logic                alu_lt;
   rar_pkg::alu_op_type alu_op;

   logic          s1, s2, num_neg, den_neg;
   logic [MW-1:0] num_raw, dvd, rem_sh;

   rar_mult #(.W(W)) u_mult (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   rar_alu #(.MW(MW)) u_alu (
      .a  (alu_a),
      .b  (alu_b),
      .op (alu_op),
      .y  (alu_y),
      .lt (alu_lt)
   );

   // signs of the two numerator terms and of the denominator, zero products count as positive
   always_comb begin
      s1 = (an_neg_ff ^ ((act_ff == rar_pkg::ACT_MUL) ? bn_neg_ff : bd_neg_ff))
           & (p1_ff != '0);
      s2 = (ad_neg_ff ^ bn_neg_ff ^ (act_ff == rar_pkg::ACT_SUB)) & (p2_ff != '0);
      den_neg = (ad_neg_ff ^ ((act_ff == rar_pkg::ACT_DIV) ? bn_neg_ff : bd_neg_ff))
                & (prod != '0);
   end

   always_comb begin
      dvd    = (state_ff == ST_DIVN) ? nq_ff : dq_ff;
      rem_sh = {v_ff[MW-2:0], dvd[MW-1]};
   end

   // operand steering for the shared units
   always_comb begin
      case (state_ff)
         ST_MUL1: begin
            mul_a = an_ff;
            mul_b = (act_ff == rar_pkg::ACT_MUL) ? bn_ff : bd_ff;
         end
         ST_MUL2: begin
            mul_a = ad_ff;
            mul_b = bn_ff;
         end
         default: begin
            mul_a = ad_ff;
            mul_b = (act_ff == rar_pkg::ACT_DIV) ? bn_ff : bd_ff;
         end
      endcase
      case (state_ff)
         ST_COMB: begin
            alu_a  = p1_ff;
            alu_b  = p2_ff;
            alu_op = (s1 == s2) ? rar_pkg::ALU_ADD : rar_pkg::ALU_ABSDIFF;
         end
         ST_DIVN, ST_DIVD: begin
            alu_a  = rem_sh;
            alu_b  = u_ff;
            alu_op = rar_pkg::ALU_ABSDIFF;
         end
         default: begin
            alu_a  = u_ff;
            alu_b  = v_ff;
            alu_op = rar_pkg::ALU_ABSDIFF;
         end
      endcase
   end

   always_comb begin
      if ((act_ff == rar_pkg::ACT_MUL) || (act_ff == rar_pkg::ACT_DIV)) begin
         num_raw = p1_ff;
         num_neg = s1;
      end else begin
         num_raw = alu_y;
         num_neg = (s1 != s2 && alu_lt) ? s2 : s1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      an_in     = an_ff;
      ad_in     = ad_ff;
      bn_in     = bn_ff;
      bd_in     = bd_ff;
      an_neg_in = an_neg_ff;
      ad_neg_in = ad_neg_ff;
      bn_neg_in = bn_neg_ff;
      bd_neg_in = bd_neg_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      nq_in     = nq_ff;
      dq_in     = dq_ff;
      cnt_in    = cnt_ff;
      flags_in  = flags_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in    = action;
               an_neg_in = a_num[W-1];
               ad_neg_in = a_den[W-1];
               bn_neg_in = b_num[W-1];
               bd_neg_in = b_den[W-1];
               an_in     = a_num[W-1] ? (~a_num + W'(1)) : a_num;
               ad_in     = a_den[W-1] ? (~a_den + W'(1)) : a_den;
               bn_in     = b_num[W-1] ? (~b_num + W'(1)) : b_num;
               bd_in     = b_den[W-1] ? (~b_den + W'(1)) : b_den;
               state_in  = ST_MUL1;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: begin
            p1_in    = prod;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            p2_in    = prod;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            flags_in.num_neg = num_neg;
            flags_in.den_neg = den_neg;
            flags_in.status  = 1'b0;
            if (prod == '0) begin
               // zero denominator: error, both fields zero
               nq_in            = '0;
               dq_in            = '0;
               flags_in.num_neg = 1'b0;
               flags_in.den_neg = 1'b0;
               flags_in.status  = 1'b1;
               state_in         = ST_DONE;
            end else if (num_raw == '0) begin
               // zero numerator reads as 0/1
               nq_in            = '0;
               dq_in            = MW'(1);
               flags_in.num_neg = 1'b0;
               flags_in.den_neg = 1'b0;
               state_in         = ST_DONE;
            end else begin
               u_in     = num_raw;
               v_in     = prod;
               nq_in    = num_raw;
               dq_in    = prod;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (v_ff == '0) begin
               // odd part of the gcd in u, common powers of two already removed
               cnt_in   = CW'(MW - 1);
               state_in = ST_DIVN;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in  = u_ff >> 1;
               v_in  = v_ff >> 1;
               nq_in = nq_ff >> 1;
               dq_in = dq_ff >> 1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else begin
               u_in = alu_lt ? u_ff : v_ff;
               v_in = alu_y;
            end
         end
         ST_DIVN, ST_DIVD: begin
            // restoring division, one quotient bit per cycle
            v_in = alu_lt ? rem_sh : alu_y;
            if (state_ff == ST_DIVN) begin
               nq_in = {nq_ff[MW-2:0], ~alu_lt};
            end else begin
               dq_in = {dq_ff[MW-2:0], ~alu_lt};
            end
            if (cnt_ff == '0) begin
               cnt_in = CW'(MW - 1);
               if (state_ff == ST_DIVN) begin
                  v_in     = '0;
                  state_in = ST_DIVD;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      act_ff    <= act_in;
      an_ff     <= an_in;
      ad_ff     <= ad_in;
      bn_ff     <= bn_in;
      bd_ff     <= bd_in;
      an_neg_ff <= an_neg_in;
      ad_neg_ff <= ad_neg_in;
      bn_neg_ff <= bn_neg_in;
      bd_neg_ff <= bd_neg_in;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      nq_ff     <= nq_in;
      dq_ff     <= dq_in;
      cnt_ff    <= cnt_in;
      flags_ff  <= flags_in;
   end

   assign idle    = (state_ff == ST_IDLE);
   assign done    = (state_ff == ST_DONE);
   assign num_mag = nq_ff;
   assign den_mag = dq_ff;
   assign flags   = flags_ff;

endmodule

// File: hdl/rational_arith_reduce.sv
// Top level of the rational fraction reducer: stream ports, output register.
// Depends on rar_pkg and rar_core (which uses rar_mult and rar_alu).
//
//   Channel   Dir  Handshake             Payload
//   req_      in   req_tvalid/tready     action, a_num, a_den, b_num, b_den
//   rsp_      out  rsp_tvalid/tready     res_num, res_den; status in tuser
//
// One transaction runs through the multiply states MUL1, MUL2 and MUL3,
// the combine state, a data-dependent binary-GCD loop and two restoring
// divisions, numerator first; the GCD loop and the shared subtractor set
// its length. A zero numerator or denominator skips the loop and divisions.
// Reset is synchronous and clears only the sequencer and rsp_tvalid.
// req_tready is low while a transaction is in work; a finished result waits
// in the output register, so the next request is taken while rsp_ stalls.
module rational_arith_reduce #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] action, then a_num, a_den, b_num, b_den (OPERAND_WIDTH each)
   input  logic [((rar_pkg::ACTION_WIDTH + 4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // response
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [32:0] res_num, [65:33] res_den, rest zero
   output logic [rar_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // [0] status
   output logic                               rsp_tuser
);

   localparam int W    = OPERAND_WIDTH;
   localparam int MW   = 2 * W;
   localparam int RW   = rar_pkg::RES_WIDTH;
   localparam int XW   = (MW + 1 > RW) ? MW + 1 : RW;
   localparam int AW   = rar_pkg::ACTION_WIDTH;
   localparam int PADW = rar_pkg::RSP_DATA_WIDTH - 2 * RW;

   logic                   core_idle, core_done, core_take;
   logic [MW-1:0]          num_mag, den_mag;
   rar_pkg::rar_flags_type flags;

   logic [MW:0]            num_tc, den_tc;
   logic [XW-1:0]          num_x, den_x;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]          rsp_num_ff, rsp_num_in, rsp_den_ff, rsp_den_in;
   logic                   rsp_status_ff, rsp_status_in;

   // unpack the request and hand it to the sequencer
   rar_core #(.W(W)) u_core (
      .clock   (clock),
      .reset   (reset),
      .start   (req_tvalid && core_idle),
      .action  (rar_pkg::action_type'(req_tdata[AW-1:0])),
      .a_num   (req_tdata[AW + W - 1     : AW]),
      .a_den   (req_tdata[AW + 2 * W - 1 : AW + W]),
      .b_num   (req_tdata[AW + 3 * W - 1 : AW + 2 * W]),
      .b_den   (req_tdata[AW + 4 * W - 1 : AW + 3 * W]),
      .idle    (core_idle),
      .done    (core_done),
      .take    (core_take),
      .num_mag (num_mag),
      .den_mag (den_mag),
      .flags   (flags)
   );

   assign req_tready = core_idle;

   // load the output slot when it is empty or being drained this cycle
   assign core_take = core_done && (!rsp_valid_ff || rsp_tready);

   // sign-magnitude to two's complement, wrap or extend to the result width
   always_comb begin
      num_tc = flags.num_neg ? (~{1'b0, num_mag} + (MW + 1)'(1)) : {1'b0, num_mag};
      den_tc = flags.den_neg ? (~{1'b0, den_mag} + (MW + 1)'(1)) : {1'b0, den_mag};
      num_x  = XW'(signed'(num_tc));
      den_x  = XW'(signed'(den_tc));
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_den_in    = rsp_den_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (core_take) begin
         rsp_valid_in  = 1'b1;
         rsp_num_in    = num_x[RW-1:0];
         rsp_den_in    = den_x[RW-1:0];
         rsp_status_in = flags.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_num_ff    <= rsp_num_in;
      rsp_den_ff    <= rsp_den_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PADW'(0), rsp_den_ff, rsp_num_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: hdl/rar_checker.sv
// Port-level checks of the rational reducer, bound to the top level.
// Depends on rar_pkg and rational_arith_reduce_defines.svh.
`include "rational_arith_reduce_defines.svh"

module rar_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rar_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                               rsp_tuser
);

   localparam int RW = rar_pkg::RES_WIDTH;

   logic [RW-1:0] res_num, res_den;

   assign res_num = rsp_tdata[RW-1:0];
   assign res_den = rsp_tdata[2*RW-1:RW];

   `RAR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp transaction changed while stalled")
   `RAR_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "request taken while previous one in work")
   `RAR_ASSERT_NOW(a_err_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "error result carries nonzero fields")
   `RAR_ASSERT_NOW(a_ok_den, rsp_tvalid && !rsp_tuser, res_den != '0, "good result with zero denominator")
   `RAR_ASSERT_NOW(a_zero_num, rsp_tvalid && !rsp_tuser && res_num == '0, res_den == RW'(1), "zero numerator not reduced to 0/1")

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (.*);
